// ===== rtl/core/sbfr_pkg.sv =====
// shared types, codes and constants of the sbus frame receiver
`timescale 1ns / 1ps

package sbfr_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN = 25;
    localparam int unsigned FB_LEN    = FRAME_LEN - 2;   // bytes 1..23 kept in the shift line
    localparam int unsigned POS_W     = $clog2(FRAME_LEN);
    localparam int unsigned NUM_CH    = 10;
    localparam int unsigned CH_W      = 11;
    localparam int unsigned CH_BYTES  = 14;               // bytes 1..14 carry the channels
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned TICK_W    = 17;
    localparam int unsigned TMO_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] FOOTER_BYTE = 8'h00;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // channels that feed the mode bits
    localparam int unsigned CH_BOOST   = 6;
    localparam int unsigned CH_BRAKE   = 8;
    localparam int unsigned CH_FORWARD = 9;

    // flag bits of byte 23
    localparam int unsigned LOST_BIT = 2;
    localparam int unsigned OFF_BIT  = 3;

    // register reset values
    localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd100;
    localparam logic [CH_W-1:0]  BOOST_RST   = 11'd1000;
    localparam logic [CH_W-1:0]  FORWARD_RST = 11'd1000;
    localparam logic [CH_W-1:0]  BRAKE_RST   = 11'd1500;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE   = 2'd3;

    // item and result codes
    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_TICK      = 1'b1;
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_chan_arr;

    typedef struct packed {
        logic       fwd;
        logic       brake;
        logic       boost;
    } t_mode;

    // one result-producing job handed from the frame core to the result sequencer
    typedef struct packed {
        logic       valid;
        logic       kind;
        t_chan_arr  ch;
        logic       lost;
        logic       fs;
        t_mode      mode;
    } t_job;

    // channels are packed little endian, 11 bits each, from byte 1 upward
    function automatic t_chan_arr unpack_frame(input logic [CH_BYTES*8-1:0] bytes);
        t_chan_arr ch;
        ch = bytes[NUM_CH*CH_W-1:0];
        return ch;
    endfunction

endpackage

// ===== rtl/core/sbfr_core.sv =====
// input register, frame assembly, flags, tick counter and registers
`timescale 1ns / 1ps

module sbfr_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_opcode,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_cfg_we,
    input  logic [sbfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbfr_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_job_ready,
    output sbfr_pkg::t_job                 o_job
);
    import sbfr_pkg::*;

    logic                r_in_valid;
    logic                r_in_op;
    logic [7:0]          r_in_byte;
    logic [POS_W-1:0]    r_pos;
    logic [7:0]          r_fb [FB_LEN];
    logic                r_lost;
    logic                r_off;
    t_mode               r_mode;
    logic [TICK_W-1:0]   r_ticks;
    logic [TMO_W-1:0]    r_timeout;
    logic [CH_W-1:0]     r_boost_th;
    logic [CH_W-1:0]     r_fwd_th;
    logic [CH_W-1:0]     r_brake_th;

    logic                is_tick;
    logic                is_byte;
    logic                frame_done;
    logic                frame_good;
    logic                has_result;
    logic                consume;
    logic                in_ready;
    logic                do_shift;
    logic [TICK_W-1:0]   n_ticks;
    logic [CH_BYTES*8-1:0] ch_bytes;
    t_chan_arr           ch;
    t_mode               n_mode;
    logic                n_lost;
    logic                n_off;

    // item decode
    assign is_tick    = r_in_op == OP_TICK;
    assign is_byte    = r_in_op == OP_BYTE;
    assign frame_done = is_byte && (r_pos == POS_W'(FRAME_LEN - 1));
    assign frame_good = frame_done && (r_in_byte == FOOTER_BYTE);
    assign has_result = is_tick || frame_good;
    assign consume    = r_in_valid && (!has_result || i_job_ready);
    assign in_ready   = !r_in_valid || consume;
    assign o_in_ready = in_ready;
    assign do_shift   = consume && is_byte && (r_pos != '0) && !frame_done;

    // saturating tick count
    assign n_ticks = (r_ticks < TICK_MAX) ? r_ticks + TICK_W'(1) : r_ticks;

    // frame unpack and mode compare
    always_comb begin
        for (int i = 0; i < CH_BYTES; i++) begin
            ch_bytes[8*i +: 8] = r_fb[i];
        end
    end

    assign ch            = unpack_frame(ch_bytes);
    assign n_lost        = r_fb[FB_LEN-1][LOST_BIT];
    assign n_off         = r_fb[FB_LEN-1][OFF_BIT];
    assign n_mode.fwd    = ch[CH_FORWARD] < r_fwd_th;
    assign n_mode.brake  = ch[CH_BRAKE] > r_brake_th;
    assign n_mode.boost  = ch[CH_BOOST] < r_boost_th;

    // job toward the result sequencer
    always_comb begin
        o_job.valid = r_in_valid && has_result;
        o_job.ch    = ch;
        if (is_tick) begin
            o_job.kind = KIND_STATUS;
            o_job.lost = r_lost;
            o_job.fs   = (n_ticks > {1'b0, r_timeout}) || r_off;
            o_job.mode = r_mode;
        end else begin
            o_job.kind = KIND_CHANNEL;
            o_job.lost = n_lost;
            o_job.fs   = n_off;
            o_job.mode = n_mode;
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && in_ready) begin
            r_in_op   <= i_opcode;
            r_in_byte <= i_rx_byte;
        end
    end

    // byte shift line, bytes 1..23 of the frame
    always_ff @(posedge i_clk) begin
        if (do_shift) begin
            for (int i = 0; i < FB_LEN - 1; i++) begin
                r_fb[i] <= r_fb[i+1];
            end
            r_fb[FB_LEN-1] <= r_in_byte;
        end
    end

    // frame position, flags, mode and tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_lost  <= 1'b0;
            r_off   <= 1'b0;
            r_mode  <= '0;
            r_ticks <= '0;
        end else if (consume) begin
            if (is_tick) begin
                r_ticks <= n_ticks;
            end else if (r_pos == '0) begin
                if (r_in_byte == HEADER_BYTE) begin
                    r_pos <= POS_W'(1);
                end
            end else if (frame_done) begin
                r_pos <= '0;
                if (frame_good) begin
                    r_lost  <= n_lost;
                    r_off   <= n_off;
                    r_mode  <= n_mode;
                    r_ticks <= '0;
                end
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RST;
            r_boost_th <= BOOST_RST;
            r_fwd_th   <= FORWARD_RST;
            r_brake_th <= BRAKE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT: r_timeout  <= i_cfg_data[TMO_W-1:0];
                CFG_BOOST:   r_boost_th <= i_cfg_data[CH_W-1:0];
                CFG_FORWARD: r_fwd_th   <= i_cfg_data[CH_W-1:0];
                CFG_BRAKE:   r_brake_th <= i_cfg_data[CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/sbfr_out_seq.sv =====
// result register and channel sequencer, one result per cycle while i_out_ready is high
`timescale 1ns / 1ps

module sbfr_out_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sbfr_pkg::t_job             i_job,
    output logic                       o_job_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_result_kind,
    output logic [sbfr_pkg::IDX_W-1:0] o_channel_index,
    output logic [sbfr_pkg::CH_W-1:0]  o_channel_value,
    output logic                       o_frame_lost,
    output logic                       o_failsafe,
    output logic                       o_forward,
    output logic                       o_handbrake,
    output logic                       o_boost,
    output logic                       o_last
);
    import sbfr_pkg::*;

    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    t_chan_arr          r_ch;
    logic               r_lost;
    logic               r_fs;
    t_mode              r_mode;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [IDX_W-1:0]   r_out_idx;
    logic [CH_W-1:0]    r_out_val;
    logic               r_out_lost;
    logic               r_out_fs;
    t_mode              r_out_mode;
    logic               r_out_last;

    logic               load;
    logic               seq_last;
    logic               take_job;

    assign load        = !r_out_valid || i_out_ready;
    assign o_job_ready = !r_busy && load;
    assign take_job    = o_job_ready && i_job.valid;
    assign seq_last    = r_idx == IDX_W'(NUM_CH - 1);

    // sequencer and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_idx       <= '0;
        end else if (load) begin
            if (r_busy) begin
                r_out_valid <= 1'b1;
                r_busy      <= !seq_last;
                r_idx       <= r_idx + IDX_W'(1);
            end else if (i_job.valid) begin
                r_out_valid <= 1'b1;
                r_busy      <= i_job.kind == KIND_CHANNEL;
                r_idx       <= IDX_W'(1);
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // frame hold for channels 1..9
    always_ff @(posedge i_clk) begin
        if (take_job) begin
            r_ch   <= i_job.ch;
            r_lost <= i_job.lost;
            r_fs   <= i_job.fs;
            r_mode <= i_job.mode;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_busy) begin
                r_out_kind <= KIND_CHANNEL;
                r_out_idx  <= r_idx;
                r_out_val  <= r_ch[r_idx];
                r_out_lost <= r_lost;
                r_out_fs   <= r_fs;
                r_out_mode <= r_mode;
                r_out_last <= seq_last;
            end else begin
                r_out_kind <= i_job.kind;
                r_out_idx  <= '0;
                r_out_lost <= i_job.lost;
                r_out_fs   <= i_job.fs;
                r_out_mode <= i_job.mode;
                r_out_last <= i_job.kind == KIND_STATUS;
                r_out_val  <= (i_job.kind == KIND_CHANNEL) ? i_job.ch[0] : '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_channel_index = r_out_idx;
    assign o_channel_value = r_out_val;
    assign o_frame_lost    = r_out_lost;
    assign o_failsafe      = r_out_fs;
    assign o_forward       = r_out_mode.fwd;
    assign o_handbrake     = r_out_mode.brake;
    assign o_boost         = r_out_mode.boost;
    assign o_last          = r_out_last;

endmodule

// ===== rtl/core/sbus_frame_receiver.sv =====
// top level of the sbus frame receiver
`timescale 1ns / 1ps
//
// Input channel (i_in_valid / o_in_ready) carries one item per handshake:
// a received serial byte (i_opcode = 0) or a one millisecond tick (i_opcode = 1).
// Bytes are hunted for a 0x0F header, then 24 more are collected; a frame
// with a 0x00 footer yields ten channel results (index 0..9, last on 9).
// Each tick yields one status result with o_last set.
// Output channel (o_out_valid / i_out_ready) is a registered result stage.
// With the result stage free, an accepted item passes the input register, then
// the result register, before its result is valid.
// Throughput: one item per cycle unless a result-producing item waits; a good
// frame drains its ten results back to back while i_out_ready stays high. While the
// channels drain, bytes that complete nothing are still taken every cycle;
// an item that itself produces a result waits at the input register.
// Receiver stall: the result stage holds and the input backs up behind it.
// Reset (synchronous, active low) clears the frame position, flags, mode
// bits and tick counter and loads the register defaults (timeout 100,
// boost 1000, forward 1000, brake 1500). The write port (i_cfg_we) updates
// the indexed register, with no read-back.

module sbus_frame_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_opcode,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_cfg_we,
    input  logic [sbfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbfr_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_result_kind,
    output logic [sbfr_pkg::IDX_W-1:0]     o_channel_index,
    output logic [sbfr_pkg::CH_W-1:0]      o_channel_value,
    output logic                           o_frame_lost,
    output logic                           o_failsafe,
    output logic                           o_forward,
    output logic                           o_handbrake,
    output logic                           o_boost,
    output logic                           o_last
);
    import sbfr_pkg::*;

    t_job job;
    logic job_ready;

    // frame assembly and state
    sbfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    // result sequencing
    sbfr_out_seq u_out_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (job),
        .o_job_ready     (job_ready),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_frame_lost    (o_frame_lost),
        .o_failsafe      (o_failsafe),
        .o_forward       (o_forward),
        .o_handbrake     (o_handbrake),
        .o_boost         (o_boost),
        .o_last          (o_last)
    );

`ifndef ASSERT_OFF
    // status results are single, empty and final
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_STATUS) |->
        (o_last && o_channel_index == '0 && o_channel_value == '0))
        else $error("status result malformed");

    // the last channel result is channel nine
    a_chan_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_CHANNEL && o_last) |->
        (o_channel_index == IDX_W'(NUM_CH - 1)))
        else $error("channel run ended at wrong index");

    // channel results of one frame follow back to back in index order
    a_chan_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_result_kind == KIND_CHANNEL && !o_last) |=>
        (o_out_valid && o_result_kind == KIND_CHANNEL &&
         o_channel_index == $past(o_channel_index) + IDX_W'(1)))
        else $error("channel run broken");

    // an accepted job is always followed by a valid result
    a_job_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job.valid && job_ready) |=> o_out_valid)
        else $error("accepted job produced no result");
`endif

endmodule
